>>> src/md5_pkg.sv
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned LEN_LIMIT = 56;
    localparam int unsigned BLOCK_WORDS = 16;

    // controller -> datapath commands
    typedef struct packed {
        logic       take_byte;   // store input byte, advance fill
        logic       pad_start;   // place 0x80 at fill
        logic       clr_word;    // clear word at clr index
        logic [3:0] clr_idx;
        logic       put_len;     // write bit length into words 14,15
        logic       round_init;  // load working regs from chain
        logic       round_step;  // one compression round
        logic       chain_add;   // fold working regs into chain
        logic       chain_init;  // restore initial values, empty message
    } t_md5_cmd;

    typedef struct packed {
        logic       block_full;  // fill wrapped to zero after a byte
        logic [5:0] fill;
        logic [5:0] round;
    } t_md5_sts;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amt(input logic [3:0] sel);
        logic [4:0] s;
        begin
            case (sel)
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

endpackage

>>> src/md5_stream_if.sv
interface md5_stream_if #(
    parameter int unsigned W = 8
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/md5_message_digest_core.sv
// MD5 (RFC 1321) hashing core, one message byte per input transfer.
//
// Input channel payload: {is_last, byte_valid, data_byte}. Bytes are packed
// little-endian into a 64-byte block; a full block is compressed with one
// MD5 round per cycle. After each input transfer the core checks the fill
// before it takes the next byte; the transfer completing a block is
// followed by its compression in the shared round unit first.
// A transfer with is_last closes the message: its byte (if valid) is added,
// then 0x80, zeros and the 64-bit bit length; one or two compressions follow
// (a second one when more than 55 bytes were buffered).
// Output channel payload: {digest_last, word_index, digest_word}. Four
// transfers, A to D; the core holds each word while the receiver stalls and
// takes no new input until word D is transferred.
// Reset (synchronous, active low) restores the initial chaining values and
// an empty message; the block buffer needs no clearing.
module md5_message_digest_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5_stream_if.sink  i_in,
    md5_stream_if.source o_out
);

    md5_pkg::t_md5_cmd cmd;
    md5_pkg::t_md5_sts sts;
    logic [1:0]  widx;
    logic [31:0] dword;

    md5_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_byte_valid (i_in.payload[8]),
        .i_is_last    (i_in.payload[9]),
        .o_in_ready   (i_in.ready),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_word_idx   (widx),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    md5_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in.payload[7:0]),
        .i_cmd         (cmd),
        .i_word_idx    (widx),
        .o_sts         (sts),
        .o_digest_word (dword)
    );

    assign o_out.payload = {(widx == 2'd3), widx, dword};

endmodule

>>> src/md5_ctrl.sv
module md5_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_byte_valid,
    input  logic                i_is_last,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_word_idx,
    input  md5_pkg::t_md5_sts   i_sts,
    output md5_pkg::t_md5_cmd   o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHK   = 7'b0000010,
        S_PAD   = 7'b0000100,
        S_CLR   = 7'b0001000,
        S_LEN   = 7'b0010000,
        S_ROUND = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic        r_last, n_last;     // message closing
    logic        r_final, n_final;   // current compress is the length block
    logic [3:0]  r_clr, n_clr;
    logic        r_spill, n_spill;   // pad spills into second block
    logic [1:0]  r_widx, n_widx;
    logic        accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_word_idx = r_widx;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_final = r_final;
        n_clr   = r_clr;
        n_spill = r_spill;
        n_widx  = r_widx;
        o_cmd   = '0;
        o_cmd.clr_idx = r_clr;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take_byte = i_byte_valid;
                    n_last  = i_is_last;
                    n_final = 1'b0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.block_full) begin
                    o_cmd.round_init = 1'b1;
                    n_state = S_ROUND;
                end else if (r_last) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.pad_start = 1'b1;
                n_spill = (i_sts.fill >= 6'(md5_pkg::LEN_LIMIT));
                n_clr   = i_sts.fill[5:2] + 4'd1;
                n_state = (i_sts.fill[5:2] == 4'd15) ? S_LEN : S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_word = 1'b1;
                n_clr = r_clr + 4'd1;
                if (r_clr == 4'd15) n_state = S_LEN;
            end
            S_LEN: begin
                if (r_spill) begin
                    n_clr   = 4'd0;
                    n_final = 1'b0;
                end else begin
                    o_cmd.put_len = 1'b1;
                    n_final = 1'b1;
                end
                o_cmd.round_init = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_step = 1'b1;
                if (i_sts.round == 6'd63) begin
                    o_cmd.chain_add = 1'b1;
                    if (!r_last) n_state = S_IDLE;
                    else if (r_final) begin
                        n_widx = 2'd0;
                        n_state = S_OUT;
                    end else if (r_spill) begin
                        // spilled pad: clear the whole block, then length
                        n_spill = 1'b0;
                        n_clr   = 4'd0;
                        n_state = S_CLR;
                    end else n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        o_cmd.chain_init = 1'b1;
                        n_last  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_final <= 1'b0;
            r_clr   <= '0;
            r_spill <= 1'b0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_final <= n_final;
            r_clr   <= n_clr;
            r_spill <= n_spill;
            r_widx  <= n_widx;
        end
    end

endmodule

>>> src/md5_dp.sv
module md5_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  md5_pkg::t_md5_cmd   i_cmd,
    input  logic [1:0]          i_word_idx,
    output md5_pkg::t_md5_sts   o_sts,
    output logic [31:0]         o_digest_word
);

    logic [31:0] r_chain [4];
    logic [31:0] r_blk [md5_pkg::BLOCK_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [63:0] r_total;
    logic        r_full;

    logic [1:0]  phase;
    logic [31:0] f, t, rot, bw, sum;
    logic [3:0]  g;
    logic [4:0]  s;
    logic [63:0] bits;
    logic [3:0]  wi;
    logic [4:0]  sh;
    logic [31:0] keep_mask;

    assign phase = r_round[5:4];
    assign wi = r_fill[5:2];
    assign sh = {r_fill[1:0], 3'b000};
    assign keep_mask = (32'd1 << sh) - 32'd1;
    assign bits = {r_total[60:0], 3'b000};

    always_comb begin
        unique case (phase)
            2'd0: begin f = r_d ^ (r_b & (r_c ^ r_d)); g = r_round[3:0]; end
            2'd1: begin
                f = r_c ^ (r_d & (r_b ^ r_c));
                g = 4'(r_round * 6'd5 + 6'd1);
            end
            2'd2: begin f = r_b ^ r_c ^ r_d; g = 4'(r_round * 6'd3 + 6'd5); end
            default: begin f = r_c ^ (r_b | ~r_d); g = 4'(r_round * 6'd7); end
        endcase
        bw  = r_blk[g];
        s   = md5_pkg::rot_amt({phase, r_round[1:0]});
        sum = r_a + f + bw + md5_pkg::round_k(r_round);
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
        t   = rot + r_b;
    end

    assign o_sts.block_full = r_full;
    assign o_sts.fill = r_fill;
    assign o_sts.round = r_round;
    assign o_digest_word = r_chain[i_word_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= md5_pkg::INIT_A;
            r_chain[1] <= md5_pkg::INIT_B;
            r_chain[2] <= md5_pkg::INIT_C;
            r_chain[3] <= md5_pkg::INIT_D;
            r_fill  <= '0;
            r_total <= '0;
            r_round <= '0;
            r_full  <= 1'b0;
        end else begin
            r_full <= 1'b0;
            if (i_cmd.take_byte) begin
                if (r_fill[1:0] == 2'd0) r_blk[wi] <= {24'd0, i_data_byte};
                else r_blk[wi] <= (r_blk[wi] & keep_mask) | ({24'd0, i_data_byte} << sh);
                r_fill  <= r_fill + 6'd1;
                r_total <= r_total + 64'd1;
                r_full  <= (r_fill == 6'd63);
            end
            if (i_cmd.pad_start) begin
                if (r_fill[1:0] == 2'd0) begin
                    r_blk[wi] <= {24'd0, md5_pkg::PAD_BYTE};
                end else begin
                    r_blk[wi] <= (r_blk[wi] & keep_mask)
                        | ({24'd0, md5_pkg::PAD_BYTE} << sh);
                end
            end
            if (i_cmd.clr_word) r_blk[i_cmd.clr_idx] <= '0;
            if (i_cmd.put_len) begin
                r_blk[14] <= bits[31:0];
                r_blk[15] <= bits[63:32];
            end
            if (i_cmd.round_init) begin
                r_a <= r_chain[0]; r_b <= r_chain[1];
                r_c <= r_chain[2]; r_d <= r_chain[3];
                r_round <= '0;
            end
            if (i_cmd.round_step) begin
                r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= t;
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.chain_add) begin
                r_chain[0] <= r_chain[0] + r_d;
                r_chain[1] <= r_chain[1] + t;
                r_chain[2] <= r_chain[2] + r_b;
                r_chain[3] <= r_chain[3] + r_c;
            end
            if (i_cmd.chain_init) begin
                r_chain[0] <= md5_pkg::INIT_A;
                r_chain[1] <= md5_pkg::INIT_B;
                r_chain[2] <= md5_pkg::INIT_C;
                r_chain[3] <= md5_pkg::INIT_D;
                r_fill  <= '0;
                r_total <= '0;
            end
        end
    end

endmodule
